// File: src/cwc_pkg.sv
// Shared types and constants for the congestion window controller.
// No dependencies; imported by cwc_core, congestion_window_controller and cwc_checker.
package cwc_pkg;

    localparam int unsigned WIN_W    = 16;
    localparam int unsigned SEQ_W    = 64;
    localparam int unsigned RTT_W    = 10;
    localparam int unsigned SPREAD_W = 9;
    localparam int unsigned IN_DATA_W  = 168;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [WIN_W-1:0] WIN_MAX            = 16'hFFFF;
    localparam logic [WIN_W-1:0] INIT_CEILING_RESET = 16'd16;
    localparam logic [WIN_W-1:0] MIN_WINDOW_RESET   = 16'd8;
    localparam logic [WIN_W-1:0] RESEND_FLOOR       = 16'd8;

    localparam logic [RTT_W-1:0]    RTT_RESET    = 10'd50;
    localparam logic [RTT_W-1:0]    RTT_MIN      = 10'd5;
    localparam logic [RTT_W-1:0]    RTT_MAX      = 10'd1000;
    localparam logic [SPREAD_W-1:0] SPREAD_RESET = 9'd25;
    localparam logic [RTT_W-1:0]    SPREAD_MIN   = 10'd2;
    localparam logic [RTT_W-1:0]    SPREAD_MAX   = 10'd500;
    localparam logic [15:0]         SAMPLE_MAX   = 16'd1000;

    localparam logic [RTT_W-1:0] TICK_RTT_FLOOR = 10'd10;
    localparam logic [13:0]      TICK_MIN_DELAY = 14'd100;
    localparam logic [13:0]      TICK_MAX_DELAY = 14'd2000;

    // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT, floor(x/9) likewise, exact for 16-bit x
    localparam logic [16:0] DIV3_MUL   = 17'd43691;
    localparam int unsigned DIV3_SHIFT = 17;
    localparam logic [15:0] DIV9_MUL   = 16'd58255;
    localparam int unsigned DIV9_SHIFT = 19;

    typedef enum logic [2:0] {
        KIND_START  = 3'd0,
        KIND_ACK    = 3'd1,
        KIND_LOSS   = 3'd2,
        KIND_TICK   = 3'd3,
        KIND_RTT    = 3'd4,
        KIND_RESEND = 3'd5
    } t_kind;

    typedef enum logic {
        REG_INITIAL_CEILING = 1'b0,
        REG_MINIMUM_WINDOW  = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] time_ms;
        logic [15:0]      loss_last_offset;
        logic             loss_present;
        logic [15:0]      rtt_sample;
    } t_item;

    typedef struct packed {
        logic [WIN_W-1:0] initial_ceiling;
        logic [WIN_W-1:0] minimum_window;
    } t_cfg;

    typedef struct packed {
        logic [WIN_W-1:0]    window;
        logic [WIN_W-1:0]    ceiling;
        logic [RTT_W-1:0]    smoothed_rtt;
        logic [SPREAD_W-1:0] rtt_variation;
        logic                in_slow_start;
    } t_result;

    function automatic logic [WIN_W-1:0] at_least(input logic [WIN_W-1:0] floor_v,
                                                  input logic [WIN_W-1:0] v);
        return (v < floor_v) ? floor_v : v;
    endfunction

endpackage

// File: src/cwc_core.sv
// Controller state and its combinational update for one event item.
// Depends on cwc_pkg.
module cwc_core
    import cwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [WIN_W-1:0]    r_window,      n_window;
    logic [WIN_W-1:0]    r_ceiling,     n_ceiling;
    logic [RTT_W-1:0]    r_rtt,         n_rtt;
    logic [SPREAD_W-1:0] r_spread,      n_spread;
    logic [SEQ_W-1:0]    r_last_acked,  n_last_acked;
    logic [SEQ_W-1:0]    r_last_tick,   n_last_tick;
    logic                r_slow,        n_slow;
    logic                r_loss_seen,   n_loss_seen;
    logic                r_first,       n_first;
    logic [WIN_W-1:0]    r_tally,       n_tally;

    logic [WIN_W-1:0] half;
    logic [WIN_W-1:0] doubled;
    logic [SEQ_W:0]   loss_end;
    logic             beyond;
    logic [17:0]      blend;
    logic [32:0]      prod3;
    logic [31:0]      prod9;
    logic [WIN_W-1:0] loss_window;
    logic [WIN_W-1:0] tick_window;
    logic [13:0]      rtt_x10;
    logic [13:0]      delay_raw;
    logic [13:0]      delay;
    logic [SEQ_W:0]   elapsed;
    logic             fire;
    logic [WIN_W-1:0] limit;
    logic [RTT_W-1:0] sample;
    logic [RTT_W-1:0] diff;
    logic [11:0]      spread_sum;
    logic [12:0]      rtt_sum;
    logic [RTT_W-1:0] rtt_pre;
    logic [RTT_W-1:0] spread_pre;

    always_comb begin
        half    = {1'b0, r_ceiling[WIN_W-1:1]};
        doubled = r_window[WIN_W-1] ? WIN_MAX : {r_window[WIN_W-2:0], 1'b0};

        loss_end = {1'b0, i_item.seq} + {49'd0, i_item.loss_last_offset};
        beyond   = {1'b0, r_last_acked} < loss_end;
        blend    = {2'b00, r_ceiling} + {1'b0, r_ceiling, 1'b0} + {2'b00, r_window};
        prod3    = {17'd0, r_window} * {16'd0, DIV3_MUL};
        loss_window = at_least(i_cfg.minimum_window,
                               r_window - prod3[DIV3_SHIFT+WIN_W-1:DIV3_SHIFT]);

        rtt_x10   = {1'b0, r_rtt, 3'b000} + {3'b000, r_rtt, 1'b0};
        delay_raw = (r_rtt > TICK_RTT_FLOOR) ? rtt_x10 : TICK_MIN_DELAY;
        delay     = (delay_raw > TICK_MAX_DELAY) ? TICK_MAX_DELAY : delay_raw;
        elapsed   = {1'b0, i_item.time_ms} - {1'b0, r_last_tick};
        fire      = !elapsed[SEQ_W] && (elapsed[SEQ_W-1:0] >= {50'd0, delay});
        limit     = at_least(RESEND_FLOOR, {1'b0, r_window[WIN_W-1:1]});
        prod9     = {16'd0, r_window} * {16'd0, DIV9_MUL};
        tick_window = at_least(i_cfg.minimum_window,
                               r_window - {3'b000, prod9[31:DIV9_SHIFT]});

        sample     = i_item.rtt_sample[RTT_W-1:0];
        diff       = (r_rtt > sample) ? (r_rtt - sample) : (sample - r_rtt);
        spread_sum = {3'b000, r_spread} + {2'b00, r_spread, 1'b0} + {2'b00, diff};
        rtt_sum    = {r_rtt, 3'b000} - {3'b000, r_rtt} + {3'b000, sample};
        if (r_first) begin
            rtt_pre    = sample;
            spread_pre = {1'b0, sample[RTT_W-1:1]};
        end else begin
            rtt_pre    = rtt_sum[12:3];
            spread_pre = spread_sum[11:2];
        end

        n_window     = r_window;
        n_ceiling    = r_ceiling;
        n_rtt        = r_rtt;
        n_spread     = r_spread;
        n_last_acked = r_last_acked;
        n_last_tick  = r_last_tick;
        n_slow       = r_slow;
        n_loss_seen  = r_loss_seen;
        n_first      = r_first;
        n_tally      = r_tally;

        unique case (i_item.kind)
            KIND_START: begin
                n_window     = i_cfg.minimum_window;
                n_ceiling    = i_cfg.initial_ceiling;
                n_rtt        = RTT_RESET;
                n_spread     = SPREAD_RESET;
                n_last_acked = i_item.seq;
                n_last_tick  = i_item.time_ms;
                n_slow       = 1'b1;
                n_loss_seen  = 1'b0;
                n_first      = 1'b1;
                n_tally      = '0;
            end
            KIND_ACK: begin
                if (i_item.seq > r_last_acked) begin
                    n_last_acked = i_item.seq;
                    if (r_slow) begin
                        if (doubled >= half) begin
                            n_slow   = 1'b0;
                            n_window = at_least(i_cfg.minimum_window, half);
                        end else begin
                            n_window = doubled;
                        end
                    end else if (r_loss_seen) begin
                        n_loss_seen = 1'b0;
                    end else begin
                        n_window = (r_window == WIN_MAX) ? WIN_MAX : r_window + 16'd1;
                        if (n_window < half) begin
                            n_slow = 1'b1;
                        end
                    end
                end
            end
            KIND_LOSS: begin
                n_slow      = 1'b0;
                n_loss_seen = 1'b1;
                if (i_item.loss_present && beyond) begin
                    if (!r_loss_seen) begin
                        n_ceiling = blend[17:2];
                    end
                    n_window = loss_window;
                end
            end
            KIND_TICK: begin
                if (fire) begin
                    n_last_tick = i_item.time_ms;
                    if (!r_slow) begin
                        n_tally = '0;
                        if (r_tally > limit) begin
                            n_window = tick_window;
                        end
                    end
                end
            end
            KIND_RTT: begin
                if (i_item.rtt_sample <= SAMPLE_MAX) begin
                    n_first = 1'b0;
                    if (rtt_pre < RTT_MIN) begin
                        n_rtt = RTT_MIN;
                    end else if (rtt_pre > RTT_MAX) begin
                        n_rtt = RTT_MAX;
                    end else begin
                        n_rtt = rtt_pre;
                    end
                    if (spread_pre < SPREAD_MIN) begin
                        n_spread = SPREAD_MIN[SPREAD_W-1:0];
                    end else if (spread_pre > SPREAD_MAX) begin
                        n_spread = SPREAD_MAX[SPREAD_W-1:0];
                    end else begin
                        n_spread = spread_pre[SPREAD_W-1:0];
                    end
                end
            end
            KIND_RESEND: begin
                n_tally = (r_tally == WIN_MAX) ? WIN_MAX : r_tally + 16'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= MIN_WINDOW_RESET;
            r_ceiling    <= INIT_CEILING_RESET;
            r_rtt        <= RTT_RESET;
            r_spread     <= SPREAD_RESET;
            r_last_acked <= '0;
            r_last_tick  <= '0;
            r_slow       <= 1'b1;
            r_loss_seen  <= 1'b0;
            r_first      <= 1'b1;
            r_tally      <= '0;
        end else if (i_en) begin
            r_window     <= n_window;
            r_ceiling    <= n_ceiling;
            r_rtt        <= n_rtt;
            r_spread     <= n_spread;
            r_last_acked <= n_last_acked;
            r_last_tick  <= n_last_tick;
            r_slow       <= n_slow;
            r_loss_seen  <= n_loss_seen;
            r_first      <= n_first;
            r_tally      <= n_tally;
        end
    end

    assign o_result = '{
        window:        n_window,
        ceiling:       n_ceiling,
        smoothed_rtt:  n_rtt,
        rtt_variation: n_spread,
        in_slow_start: n_slow
    };

endmodule

// File: src/congestion_window_controller.sv
// An accepted item is registered at the input, its result in the output (or skid) register.
// Throughput: one item per cycle without stall; the state update is one pass through cwc_core.
// Output plus skid register: two-entry result stage; input is taken while skid or input is free.
// Reset (synchronous, active low) restores registers 16/8 and the controller state.
// Depends on cwc_pkg and cwc_core.
module congestion_window_controller
    import cwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // seq[63:0], time_ms[127:64], loss_last_offset[143:128], loss_present[144],
    // rtt_sample[160:145], zero pad[167:161]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // window[15:0], ceiling[31:16], smoothed_rtt[41:32], rtt_variation[50:42],
    // in_slow_start[51], zero pad[55:52]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    t_result result;
    logic    in_take;
    logic    advance;
    logic    out_take;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (t_reg_index'(paddr[2]) == REG_MINIMUM_WINDOW)
                     ? {16'd0, r_cfg.minimum_window}
                     : {16'd0, r_cfg.initial_ceiling};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_ceiling <= INIT_CEILING_RESET;
            r_cfg.minimum_window  <= MIN_WINDOW_RESET;
        end else if (cfg_write) begin
            unique case (t_reg_index'(paddr[2]))
                REG_INITIAL_CEILING: r_cfg.initial_ceiling <= pwdata[WIN_W-1:0];
                REG_MINIMUM_WINDOW:  r_cfg.minimum_window  <= pwdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !r_in_valid || !r_skid_valid;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign advance       = r_in_valid && !r_skid_valid;
    assign out_take      = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.kind             <= s_axis_tuser;
            r_in_item.seq              <= s_axis_tdata[63:0];
            r_in_item.time_ms          <= s_axis_tdata[127:64];
            r_in_item.loss_last_offset <= s_axis_tdata[143:128];
            r_in_item.loss_present     <= s_axis_tdata[144];
            r_in_item.rtt_sample       <= s_axis_tdata[160:145];
        end
    end

    cwc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (advance) begin
            if (!r_out_valid || out_take) begin
                r_out       <= result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.in_slow_start, r_out.rtt_variation,
                            r_out.smoothed_rtt, r_out.ceiling, r_out.window};

endmodule

// File: src/cwc_checker.sv
// Port-level checks for congestion_window_controller, bound to the top level.
// Depends on cwc_pkg.
module cwc_checker
    import cwc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item dropped or changed under stall");

    a_ready_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready && m_axis_tvalid))
        else $error("input stalled without a waiting result");

    a_rtt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[41:32] >= RTT_MIN && m_axis_tdata[41:32] <= RTT_MAX)
        else $error("smoothed rtt out of range");

    a_spread_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[50:42] >= SPREAD_MIN[SPREAD_W-1:0]
                       && m_axis_tdata[50:42] <= SPREAD_MAX[SPREAD_W-1:0])
        else $error("rtt variation out of range");

endmodule

bind congestion_window_controller cwc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/congestion_window_controller_tb.sv
// Self-checking testbench for congestion_window_controller: directed corner events, then
// resend-shrink and random traffic over several register settings, with random stalls.
// Depends on cwc_pkg and the controller RTL; results are checked against an in-bench model.
module congestion_window_controller_tb;
    import cwc_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int unsigned IDLE_PCT = 33;
    localparam logic [63:0] ALL_ONES = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // window controller model state
    int unsigned cfg_ceiling;
    int unsigned cfg_min_window;
    int unsigned cw_window;
    int unsigned cw_ceiling;
    int unsigned cw_rtt;
    int unsigned cw_spread;
    logic [63:0] cw_last_acked;
    logic [63:0] cw_last_tick;
    logic        cw_slow;
    logic        cw_loss_seen;
    logic        cw_first_sample;
    int unsigned cw_resends;

    t_result     window_results_q[$];
    int unsigned fail_count = 0;
    int unsigned idle_pct = IDLE_PCT;
    logic [63:0] traffic_seq;
    logic [63:0] traffic_time;

    always #5 i_clk = ~i_clk;

    congestion_window_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic void restart_window();
        cw_ceiling      = cfg_ceiling;
        cw_window       = cfg_min_window;
        cw_rtt          = RTT_RESET;
        cw_spread       = SPREAD_RESET;
        cw_last_acked   = '0;
        cw_last_tick    = '0;
        cw_slow         = 1'b1;
        cw_loss_seen    = 1'b0;
        cw_first_sample = 1'b1;
        cw_resends      = 0;
    endfunction

    function automatic t_result advance_window(input t_item it);
        int unsigned half;
        int unsigned delay;
        int unsigned limit;
        int unsigned diff;
        logic [64:0] reach;
        t_result     res;
        case (it.kind)
            KIND_START: begin
                restart_window();
                cw_last_acked = it.seq;
                cw_last_tick  = it.time_ms;
            end
            KIND_ACK: begin
                if (it.seq > cw_last_acked) begin
                    half = cw_ceiling / 2;
                    if (cw_slow) begin
                        cw_window = cw_window * 2;
                        if (cw_window > WIN_MAX) cw_window = WIN_MAX;
                        if (cw_window >= half) begin
                            cw_slow   = 1'b0;
                            cw_window = (half < cfg_min_window) ? cfg_min_window : half;
                        end
                    end else if (cw_loss_seen) begin
                        cw_loss_seen = 1'b0;
                    end else begin
                        if (cw_window < WIN_MAX) cw_window = cw_window + 1;
                        if (cw_window < half) cw_slow = 1'b1;
                    end
                    cw_last_acked = it.seq;
                end
            end
            KIND_LOSS: begin
                cw_slow = 1'b0;
                reach = {1'b0, it.seq} + {49'd0, it.loss_last_offset};
                if (it.loss_present && reach > {1'b0, cw_last_acked}) begin
                    if (!cw_loss_seen) cw_ceiling = (cw_ceiling * 3 + cw_window) / 4;
                    cw_window = (cw_window * 2 + 2) / 3;
                    if (cw_window < cfg_min_window) cw_window = cfg_min_window;
                end
                cw_loss_seen = 1'b1;
            end
            KIND_TICK: begin
                delay = TICK_MIN_DELAY;
                if (cw_rtt > TICK_RTT_FLOOR) delay = 10 * cw_rtt;
                if (delay > TICK_MAX_DELAY) delay = TICK_MAX_DELAY;
                if (it.time_ms >= cw_last_tick && it.time_ms - cw_last_tick >= 64'(delay)) begin
                    if (!cw_slow) begin
                        limit = cw_window / 2;
                        if (limit < RESEND_FLOOR) limit = RESEND_FLOOR;
                        if (cw_resends > limit) begin
                            cw_window = (cw_window * 8 + 8) / 9;
                            if (cw_window < cfg_min_window) cw_window = cfg_min_window;
                        end
                        cw_resends = 0;
                    end
                    cw_last_tick = it.time_ms;
                end
            end
            KIND_RTT: begin
                if (it.rtt_sample <= SAMPLE_MAX) begin
                    if (cw_first_sample) begin
                        cw_first_sample = 1'b0;
                        cw_rtt    = it.rtt_sample;
                        cw_spread = it.rtt_sample / 2;
                    end else begin
                        diff = (cw_rtt > it.rtt_sample) ? cw_rtt - it.rtt_sample
                                                        : it.rtt_sample - cw_rtt;
                        cw_spread = (cw_spread * 3 + diff) / 4;
                        cw_rtt    = (7 * cw_rtt + it.rtt_sample) / 8;
                    end
                    if (cw_rtt < RTT_MIN) cw_rtt = RTT_MIN;
                    if (cw_rtt > RTT_MAX) cw_rtt = RTT_MAX;
                    if (cw_spread < SPREAD_MIN) cw_spread = SPREAD_MIN;
                    if (cw_spread > SPREAD_MAX) cw_spread = SPREAD_MAX;
                end
            end
            KIND_RESEND: begin
                if (cw_resends < WIN_MAX) cw_resends = cw_resends + 1;
            end
            default: begin
            end
        endcase
        res.window        = cw_window[WIN_W-1:0];
        res.ceiling       = cw_ceiling[WIN_W-1:0];
        res.smoothed_rtt  = cw_rtt[RTT_W-1:0];
        res.rtt_variation = cw_spread[SPREAD_W-1:0];
        res.in_slow_start = cw_slow;
        return res;
    endfunction

    function automatic void report_field(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_results_q.size() == 0) begin
                $display("%0t: unexpected result item, expected none actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = window_results_q.pop_front();
                report_field("window", want.window, m_axis_tdata[15:0]);
                report_field("ceiling", want.ceiling, m_axis_tdata[31:16]);
                report_field("smoothed_rtt", want.smoothed_rtt, m_axis_tdata[41:32]);
                report_field("rtt_variation", want.rtt_variation, m_axis_tdata[50:42]);
                report_field("in_slow_start", want.in_slow_start, m_axis_tdata[51]);
            end
        end
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= idle_pct);

    // called and left at a falling edge
    task automatic push_event(input t_item it);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.kind;
        s_axis_tdata  = {7'd0, it.rtt_sample, it.loss_present, it.loss_last_offset,
                         it.time_ms, it.seq};
        do @(posedge i_clk); while (!s_axis_tready);
        window_results_q.push_back(advance_window(it));
        @(negedge i_clk);
    endtask

    task automatic send_event(input logic [2:0] kind, input logic [63:0] seq,
                              input logic [63:0] now, input logic [15:0] offset,
                              input logic present, input logic [15:0] sample);
        t_item it;
        it.kind             = kind;
        it.seq              = seq;
        it.time_ms          = now;
        it.loss_last_offset = offset;
        it.loss_present     = present;
        it.rtt_sample       = sample;
        push_event(it);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (window_results_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [15:0] value);
        s_axis_tvalid = 1'b0;
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== value) begin
            $display("%0t: register %0d read back, expected %0d actual %0d",
                     $time, idx, value, prdata[15:0]);
            fail_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (idx == REG_INITIAL_CEILING) cfg_ceiling = value;
        else cfg_min_window = value;
    endtask

    task automatic test_directed_extremes();
        send_event(KIND_SPARE_LO, ALL_ONES, ALL_ONES, 16'hFFFF, 1'b1, 16'hFFFF);
        send_event(KIND_SPARE_HI, '0, '0, '0, 1'b0, '0);
        send_event(KIND_ACK, 64'd0, '0, '0, 1'b0, '0);
        send_event(KIND_ACK, 64'd1, '0, '0, 1'b0, '0);
        send_event(KIND_ACK, 64'd2, '0, '0, 1'b0, '0);
        send_event(KIND_LOSS, 64'd0, '0, 16'd0, 1'b0, '0);
        send_event(KIND_ACK, 64'd3, '0, '0, 1'b0, '0);
        send_event(KIND_LOSS, ALL_ONES, '0, 16'hFFFF, 1'b1, '0);
        send_event(KIND_LOSS, 64'd0, '0, 16'd0, 1'b1, '0);
        send_event(KIND_RTT, '0, '0, '0, 1'b0, 16'd0);
        send_event(KIND_RTT, '0, '0, '0, 1'b0, 16'd1000);
        send_event(KIND_RTT, '0, '0, '0, 1'b0, 16'd1001);
        send_event(KIND_RTT, '0, '0, '0, 1'b0, 16'hFFFF);
        send_event(KIND_RTT, '0, '0, '0, 1'b0, 16'd1);
        send_event(KIND_TICK, '0, 64'd0, '0, 1'b0, '0);
        send_event(KIND_TICK, '0, ALL_ONES, '0, 1'b0, '0);
        send_event(KIND_TICK, '0, 64'd5, '0, 1'b0, '0);
        send_event(KIND_RESEND, '0, '0, '0, 1'b0, '0);
        send_event(KIND_START, ALL_ONES, ALL_ONES, '0, 1'b0, '0);
        send_event(KIND_ACK, ALL_ONES, '0, '0, 1'b0, '0);
        send_event(KIND_TICK, '0, ALL_ONES, '0, 1'b0, '0);
        send_event(KIND_START, '0, '0, '0, 1'b0, '0);
    endtask

    task automatic test_resend_shrink();
        wait_drained();
        write_reg(REG_INITIAL_CEILING, 16'd64);
        write_reg(REG_MINIMUM_WINDOW, 16'd4);
        send_event(KIND_START, '0, '0, '0, 1'b0, '0);
        for (int i = 1; i <= 4; i++) send_event(KIND_ACK, 64'(i), '0, '0, 1'b0, '0);
        repeat (20) send_event(KIND_RESEND, '0, '0, '0, 1'b0, '0);
        send_event(KIND_TICK, '0, 64'd5000, '0, 1'b0, '0);
        send_event(KIND_TICK, '0, 64'd5100, '0, 1'b0, '0);
    endtask

    function automatic t_item random_event();
        t_item it;
        int unsigned pick;
        it.kind             = KIND_RESEND;
        it.seq              = {$urandom, $urandom};
        it.time_ms          = {$urandom, $urandom};
        it.loss_last_offset = 16'($urandom);
        it.loss_present     = 1'($urandom);
        it.rtt_sample       = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 3) begin
            it.kind = KIND_START;
            if ($urandom_range(4) != 0) begin
                it.seq     = 64'($urandom_range(1000));
                it.time_ms = 64'($urandom_range(100000));
            end
            traffic_seq  = it.seq;
            traffic_time = it.time_ms;
        end else if (pick < 35) begin
            it.kind = KIND_ACK;
            if ($urandom_range(9) != 0) begin
                traffic_seq = traffic_seq + 64'($urandom_range(1, 4));
                it.seq      = traffic_seq;
            end else if ($urandom_range(1) == 0) begin
                it.seq = traffic_seq - 64'($urandom_range(3));
            end
        end else if (pick < 50) begin
            it.kind = KIND_LOSS;
            it.loss_present = ($urandom_range(4) != 0);
            if ($urandom_range(19) != 0) it.seq = traffic_seq - 64'($urandom_range(20));
            if ($urandom_range(9) < 7) it.loss_last_offset = 16'($urandom_range(40));
        end else if (pick < 65) begin
            it.kind = KIND_TICK;
            if ($urandom_range(9) != 0) begin
                traffic_time = traffic_time + 64'($urandom_range(3000));
                it.time_ms   = traffic_time;
            end
        end else if (pick < 80) begin
            it.kind = KIND_RTT;
            if ($urandom_range(6) != 0) it.rtt_sample = 16'($urandom_range(1000));
        end else if (pick >= 97) begin
            it.kind = ($urandom_range(1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
        end
        return it;
    endfunction

    task automatic random_phase(input logic [15:0] ceiling, input logic [15:0] min_window,
                                input int unsigned count, input logic quiet);
        int unsigned sent;
        int unsigned burst;
        wait_drained();
        write_reg(REG_INITIAL_CEILING, ceiling);
        write_reg(REG_MINIMUM_WINDOW, min_window);
        idle_pct = quiet ? 0 : IDLE_PCT;
        traffic_seq  = 64'($urandom_range(100));
        traffic_time = 64'($urandom_range(10000));
        send_event(KIND_START, traffic_seq, traffic_time, '0, 1'b0, '0);
        sent = 1;
        while (sent < count) begin
            if ($urandom_range(24) == 0) begin
                burst = $urandom_range(10, 40);
                repeat (burst) send_event(KIND_RESEND, '0, '0, '0, 1'b0, '0);
                traffic_time = traffic_time + 64'd2500;
                send_event(KIND_TICK, '0, traffic_time, '0, 1'b0, '0);
                sent += burst + 1;
            end else begin
                push_event(random_event());
                sent++;
            end
        end
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_traffic();
        random_phase(16'd16, 16'd8, 75, 1'b0);
        random_phase(16'd8, 16'd1, 75, 1'b0);
        random_phase(16'hFFFF, 16'd1, 75, 1'b1);
        random_phase(16'hFFFF, 16'hFFFF, 75, 1'b0);
        random_phase(16'd8, 16'hFFFF, 75, 1'b0);
        random_phase(16'd1000, 16'd4, 75, 1'b0);
        random_phase(16'($urandom_range(8, 4096)), 16'($urandom_range(1, 64)), 75, 1'b0);
    endtask

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned waited;
        cfg_ceiling    = INIT_CEILING_RESET;
        cfg_min_window = MIN_WINDOW_RESET;
        restart_window();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_resend_shrink();
        test_random_traffic();
        s_axis_tvalid = 1'b0;
        waited = 0;
        while (window_results_q.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (6) @(negedge i_clk);
        if (window_results_q.size() != 0) begin
            $display("%0t: results outstanding, expected 0 actual %0d",
                     $time, window_results_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: congestion_window_controller.f
src/cwc_pkg.sv
src/cwc_core.sv
src/congestion_window_controller.sv
src/cwc_checker.sv
sim/congestion_window_controller_tb.sv
